// ===== rtl/kdm_pkg.sv =====
// ----------------------------------------------------------------------------
// kdm_pkg
// Types, constants and helpers shared by the key debouncer and its
// note-event stages.
// ----------------------------------------------------------------------------
package kdm_pkg;

  localparam int KDM_KEY_BITS = 16;
  localparam int KDM_IDX_BITS = 4;
  localparam int KDM_QDEPTH   = 2;
  localparam int KDM_AW       = 4;

  localparam logic [7:0] KDM_HDR    = 8'h08;
  localparam logic [7:0] KDM_ST_ON  = 8'h90;
  localparam logic [7:0] KDM_ST_OFF = 8'h80;

  localparam logic [6:0] KDM_RST_BASE_NOTE = 7'd60;
  localparam logic [6:0] KDM_RST_VELOCITY  = 7'd80;
  localparam logic [3:0] KDM_RST_CHANNEL   = 4'd0;
  localparam logic [7:0] KDM_RST_THRESHOLD = 8'd3;

  typedef enum logic [1:0] {
    REG_BASE_NOTE,
    REG_VELOCITY,
    REG_CHANNEL,
    REG_THRESHOLD
  } kdm_reg_t;

  typedef struct packed {
    logic [6:0] base_note;
    logic [6:0] press_velocity;
    logic [3:0] channel;
  } kdm_cfg_t;

  // one debounced scan that changed at least one key
  typedef struct packed {
    logic [KDM_KEY_BITS-1:0] changed;
    logic [KDM_KEY_BITS-1:0] stable;
  } kdm_scan_t;

  function automatic logic [KDM_IDX_BITS-1:0] kdm_lowest(
    input logic [KDM_KEY_BITS-1:0] mask
  );
    logic [KDM_IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = KDM_KEY_BITS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = i[KDM_IDX_BITS-1:0];
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/kdm_front.sv =====
// ----------------------------------------------------------------------------
// kdm_front
// Per-key debounce counters and stable key state; emits the changed mask of
// each scan that flips at least one key.
// ----------------------------------------------------------------------------
module kdm_front #(
  parameter int NUM_KEYS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [kdm_pkg::KDM_KEY_BITS-1:0] key_scan,
  input  logic [7:0]                     threshold,
  output logic                           wr,
  output kdm_pkg::kdm_scan_t             wr_data
);
  import kdm_pkg::*;

  localparam int ACT = (NUM_KEYS > KDM_KEY_BITS) ? KDM_KEY_BITS : NUM_KEYS;

  logic [KDM_KEY_BITS-1:0] stable;
  logic [KDM_KEY_BITS-1:0] stable_next;
  logic [7:0]              cnt      [ACT];
  logic [7:0]              cnt_next [ACT];

  always_comb begin
    logic [8:0] sum;
    logic       agree;
    logic       hit;
    stable_next = stable;
    for (int i = 0; i < ACT; i++) begin
      agree = (key_scan[i] == stable[i]);
      sum   = {1'b0, cnt[i]} + 9'd1;
      // threshold of zero behaves like one
      hit   = (sum >= {1'b0, threshold});
      if (agree || hit) begin
        cnt_next[i] = '0;
      end else begin
        cnt_next[i] = sum[7:0];
      end
      if (!agree && hit) begin
        stable_next[i] = key_scan[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= '0;
      for (int i = 0; i < ACT; i++) begin
        cnt[i] <= '0;
      end
    end else if (accept) begin
      stable <= stable_next;
      for (int i = 0; i < ACT; i++) begin
        cnt[i] <= cnt_next[i];
      end
    end
  end

  assign wr              = accept && (stable_next != stable);
  assign wr_data.changed = stable ^ stable_next;
  assign wr_data.stable  = stable_next;

endmodule

// ===== rtl/kdm_fifo.sv =====
// ----------------------------------------------------------------------------
// kdm_fifo
// Short queue of debounced scans between the front and the packet sequencer.
// ----------------------------------------------------------------------------
module kdm_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  kdm_pkg::kdm_scan_t wr_data,
  input  logic               rd,
  output kdm_pkg::kdm_scan_t rd_data,
  output logic               full,
  output logic               empty
);
  import kdm_pkg::*;

  localparam int AW = $clog2(KDM_QDEPTH);

  kdm_scan_t     mem [KDM_QDEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  logic do_wr;
  logic do_rd;

  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(KDM_QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(KDM_QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_data = mem[rd_ptr];
  assign full    = (count == (AW+1)'(KDM_QDEPTH));
  assign empty   = (count == '0);

endmodule

// ===== rtl/kdm_back.sv =====
// ----------------------------------------------------------------------------
// kdm_back
// Walks the changed keys of one scan in ascending order and builds one
// USB-MIDI note packet per key into the output register.
// ----------------------------------------------------------------------------
module kdm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  kdm_pkg::kdm_cfg_t                 cfg,
  input  logic                              q_empty,
  input  kdm_pkg::kdm_scan_t                q_data,
  output logic                              q_rd,
  input  logic                              pop,
  output logic                              empty,
  output logic [kdm_pkg::KDM_IDX_BITS-1:0]  key_num,
  output logic                              is_press,
  output logic [7:0]                        packet_header,
  output logic [7:0]                        status_byte,
  output logic [6:0]                        note_number,
  output logic [6:0]                        velocity_byte,
  output logic                              last_event
);
  import kdm_pkg::*;

  logic [KDM_KEY_BITS-1:0] pend;
  logic [KDM_KEY_BITS-1:0] snap;
  logic                    out_valid;

  logic                    slot_free;
  logic                    emit;
  logic [KDM_IDX_BITS-1:0] idx;
  logic [KDM_KEY_BITS-1:0] pend_next;
  logic                    press;

  assign slot_free = !out_valid || pop;
  assign q_rd      = (pend == '0) && !q_empty;
  assign emit      = (pend != '0) && slot_free;
  assign idx       = kdm_lowest(pend);
  assign pend_next = pend & ~(KDM_KEY_BITS'(1) << idx);
  assign press     = snap[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_rd) begin
        pend <= q_data.changed;
      end else if (emit) begin
        pend <= pend_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      snap <= q_data.stable;
    end
    if (emit) begin
      key_num       <= idx;
      is_press      <= press;
      packet_header <= KDM_HDR;
      status_byte   <= (press ? KDM_ST_ON : KDM_ST_OFF) | {4'b0, cfg.channel};
      note_number   <= cfg.base_note + {3'b0, idx};
      velocity_byte <= press ? cfg.press_velocity : 7'd0;
      last_event    <= (pend_next == '0);
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/key_debounce_midi_note_events_unit.sv =====
// ----------------------------------------------------------------------------
// key_debounce_midi_note_events_unit
// Counter key debouncer that turns stable key changes into USB-MIDI note
// packets.
// ----------------------------------------------------------------------------
// Usage:
//   input queue: drive key_scan and push; a scan beat is taken when full is
//   low. A scan is debounced in the cycle it is taken.
//   result queue: while empty is low the oldest note packet is on the result
//   ports; pop takes it. A scan that flips k keys gives k packets in
//   ascending key order, last_event set on the final one; a scan with no
//   flip gives none.
//   path: a scan's first packet passes the queue, then the sequencer's
//   pending mask, then the output register, before it shows on the ports.
//   sequencing: the sequencer fetches a scan from the two-entry queue once
//   its pending mask is empty, then builds one packet per key while the output
//   slot is free. Scans keep being taken while the queue has room.
//   stall: with pop low the packet holds, the sequencer waits, the queue
//   fills and full rises.
//   reset: stable keys all released, counters zero, registers 60, 80, 0, 3,
//   queues empty.
//   config: APB registers at 0x0 base_note, 0x4 press_velocity, 0x8 channel,
//   0xc debounce_threshold; user must write them only while idle (unenforced).
// ----------------------------------------------------------------------------
module key_debounce_midi_note_events_unit #(
  parameter int NUM_KEYS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [kdm_pkg::KDM_KEY_BITS-1:0]  key_scan,
  input  logic                              pop,
  output logic                              empty,
  output logic [kdm_pkg::KDM_IDX_BITS-1:0]  key_num,
  output logic                              is_press,
  output logic [7:0]                        packet_header,
  output logic [7:0]                        status_byte,
  output logic [6:0]                        note_number,
  output logic [6:0]                        velocity_byte,
  output logic                              last_event,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kdm_pkg::KDM_AW-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import kdm_pkg::*;

  logic [6:0] base_note;
  logic [6:0] press_velocity;
  logic [3:0] channel;
  logic [7:0] debounce_threshold;

  kdm_reg_t  reg_sel;
  logic      cfg_wr;
  kdm_cfg_t  cfg;

  logic      accept;
  logic      f_wr;
  kdm_scan_t f_data;
  logic      q_full;
  logic      q_empty;
  logic      q_rd;
  kdm_scan_t q_data;

  assign pready  = 1'b1;
  assign reg_sel = kdm_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_note          <= KDM_RST_BASE_NOTE;
      press_velocity     <= KDM_RST_VELOCITY;
      channel            <= KDM_RST_CHANNEL;
      debounce_threshold <= KDM_RST_THRESHOLD;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_BASE_NOTE: base_note          <= pwdata[6:0];
        REG_VELOCITY:  press_velocity     <= pwdata[6:0];
        REG_CHANNEL:   channel            <= pwdata[3:0];
        REG_THRESHOLD: debounce_threshold <= pwdata[7:0];
        default:       base_note          <= base_note;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASE_NOTE: prdata = {25'b0, base_note};
      REG_VELOCITY:  prdata = {25'b0, press_velocity};
      REG_CHANNEL:   prdata = {28'b0, channel};
      REG_THRESHOLD: prdata = {24'b0, debounce_threshold};
      default:       prdata = '0;
    endcase
  end

  assign cfg.base_note      = base_note;
  assign cfg.press_velocity = press_velocity;
  assign cfg.channel        = channel;

  assign full   = q_full;
  assign accept = push && !q_full;

  kdm_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .key_scan  (key_scan),
    .threshold (debounce_threshold),
    .wr        (f_wr),
    .wr_data   (f_data)
  );

  kdm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_wr),
    .wr_data (f_data),
    .rd      (q_rd),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  kdm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_rd          (q_rd),
    .pop           (pop),
    .empty         (empty),
    .key_num       (key_num),
    .is_press      (is_press),
    .packet_header (packet_header),
    .status_byte   (status_byte),
    .note_number   (note_number),
    .velocity_byte (velocity_byte),
    .last_event    (last_event)
  );

  // a scan that flips keys must always find room in the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_wr |-> !q_full)
    else $error("scan queue overflow");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("result pending right after reset");

  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_press) |-> (status_byte[7:4] == KDM_ST_ON[7:4]))
    else $error("note-on beat without note-on status");

  a_release_vel: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_press) |-> (velocity_byte == 7'd0 &&
      status_byte[7:4] == KDM_ST_OFF[7:4]))
    else $error("note-off beat with bad status or velocity");

endmodule

// ===== tb/sv/key_debounce_midi_note_events_unit_tb.sv =====
// ----------------------------------------------------------------------------
// key_debounce_midi_note_events_unit_tb
// Self-checking bench for the key debouncer. Scans are pushed from a queue,
// note packets are popped with random gaps and one long hold-off, and every
// packet is compared with a cycle-free model of the per-key counters.
// ----------------------------------------------------------------------------
module key_debounce_midi_note_events_unit_tb;
  import kdm_pkg::*;

  typedef struct packed {
    logic [3:0] key;
    logic       press;
    logic [7:0] hdr;
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
    logic       last;
  } note_pkt_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [15:0]         key_scan = '0;
  logic                pop = 1'b0;
  logic                empty;
  logic [3:0]          key_num;
  logic                is_press;
  logic [7:0]          packet_header;
  logic [7:0]          status_byte;
  logic [6:0]          note_number;
  logic [6:0]          velocity_byte;
  logic                last_event;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [KDM_AW-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  key_debounce_midi_note_events_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .key_scan(key_scan),
    .pop(pop), .empty(empty), .key_num(key_num), .is_press(is_press),
    .packet_header(packet_header), .status_byte(status_byte),
    .note_number(note_number), .velocity_byte(velocity_byte),
    .last_event(last_event), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state and register shadow
  logic [15:0] model_keys = '0;
  logic [7:0]  key_cnt [16];
  logic [6:0]  cfg_base   = KDM_RST_BASE_NOTE;
  logic [6:0]  cfg_vel    = KDM_RST_VELOCITY;
  logic [3:0]  cfg_chan   = KDM_RST_CHANNEL;
  logic [7:0]  cfg_thresh = KDM_RST_THRESHOLD;

  logic [15:0] scan_q [$];
  note_pkt_t   note_q [$];
  note_pkt_t   want;

  int errors = 0;
  int scans_queued = 0;
  int scans_taken = 0;
  int notes_on = 0;
  int notes_off = 0;
  int settings = 0;
  bit steady_flow = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  logic [15:0] held = '0;

  initial begin
    for (int k = 0; k < 16; k++) key_cnt[k] = '0;
  end

  // debounce one scan and queue the note packets it should give
  function automatic void predict_scan(input logic [15:0] raw);
    logic [15:0] prior;
    logic [8:0]  cnt;
    note_pkt_t   pkt;
    int          made;
    prior = model_keys;
    made = 0;
    for (int k = 0; k < 16; k++) begin
      if (raw[k] == prior[k]) begin
        key_cnt[k] = '0;
      end else begin
        cnt = {1'b0, key_cnt[k]} + 9'd1;
        if (cnt >= {1'b0, cfg_thresh}) begin
          key_cnt[k] = '0;
          model_keys[k] = raw[k];
        end else begin
          key_cnt[k] = cnt[7:0];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      if (prior[k] != model_keys[k]) begin
        pkt.key    = 4'(k);
        pkt.press  = model_keys[k];
        pkt.hdr    = KDM_HDR;
        pkt.status = (model_keys[k] ? KDM_ST_ON : KDM_ST_OFF) | {4'd0, cfg_chan};
        pkt.note   = cfg_base + 7'(k);
        pkt.vel    = model_keys[k] ? cfg_vel : 7'd0;
        pkt.last   = 1'b0;
        note_q.push_back(pkt);
        made++;
      end
    end
    if (made > 0) note_q[note_q.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // scan side: take beats at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      predict_scan(key_scan);
      void'(scan_q.pop_front());
      scans_taken++;
    end
  end

  always @(negedge clk) begin
    if (scan_q.size() > 0 && (steady_flow || $urandom_range(0, 99) >= 10)) begin
      push <= 1'b1;
      key_scan <= scan_q[0];
    end else begin
      push <= 1'b0;
    end
  end

  // packet side
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= steady_flow || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (note_q.size() == 0) begin
        errors++;
        $display("%0t: note packet with none expected, expected none actual key %0d",
                 $time, key_num);
      end else begin
        want = note_q.pop_front();
        check_field("key_num", want.key, key_num);
        check_field("is_press", want.press, is_press);
        check_field("packet_header", want.hdr, packet_header);
        check_field("status_byte", want.status, status_byte);
        check_field("note_number", want.note, note_number);
        check_field("velocity_byte", want.vel, velocity_byte);
        check_field("last_event", want.last, last_event);
        if (want.press) notes_on++;
        else notes_off++;
      end
    end
  end

  task automatic write_reg(input kdm_reg_t r, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_BASE_NOTE: cfg_base   = v[6:0];
      REG_VELOCITY:  cfg_vel    = v[6:0];
      REG_CHANNEL:   cfg_chan   = v[3:0];
      REG_THRESHOLD: cfg_thresh = v[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input int base, input int vel, input int chan, input int thr);
    write_reg(REG_BASE_NOTE, 32'(base));
    write_reg(REG_VELOCITY, 32'(vel));
    write_reg(REG_CHANNEL, 32'(chan));
    write_reg(REG_THRESHOLD, 32'(thr));
    settings++;
  endtask

  task automatic random_config(input int thr);
    set_config($urandom_range(0, 112), $urandom_range(1, 127), $urandom_range(0, 15), thr);
  endtask

  task automatic queue_scan(input logic [15:0] raw, input int n);
    repeat (n) begin
      scan_q.push_back(raw);
      scans_queued++;
    end
  endtask

  // wait for the block to drain, plus a margin for a scan with no flip
  task automatic settle();
    wait (scan_q.size() == 0 && note_q.size() == 0);
    repeat (24) @(negedge clk);
  endtask

  // a press or release of a few keys: some contact bounce, then held long enough
  task automatic add_gesture();
    logic [15:0] flip;
    logic [15:0] target;
    if ($urandom_range(0, 9) == 0) begin
      queue_scan(16'($urandom), 1);
    end else begin
      flip = 16'($urandom) & 16'($urandom) & 16'($urandom);
      if (flip == '0) flip = 16'(1) << $urandom_range(0, 15);
      target = held ^ flip;
      repeat ($urandom_range(0, 3)) queue_scan(target ^ (16'($urandom) & flip), 1);
      queue_scan(target, int'(cfg_thresh) + $urandom_range(0, 2));
      held = target;
    end
  endtask

  task automatic gesture_phase(input int n);
    int start;
    start = scans_queued;
    while (scans_queued - start < n) add_gesture();
  endtask

  initial begin
    logic [15:0] steady;
    logic [15:0] noisy;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // reset settings: threshold 3
    queue_scan(16'h0000, 1);       // no change, no packet
    queue_scan(16'hFFFF, 3);       // all sixteen press together
    queue_scan(16'hFFFE, 2);       // key 0 bounces but never reaches threshold
    queue_scan(16'hFFFF, 1);
    queue_scan(16'h0000, 3);       // all sixteen release
    queue_scan(16'h8001, 3);       // lowest and highest key
    settle();

    // highest base note for sixteen keys, top velocity and channel; every scan flips
    set_config(112, 127, 15, 1);
    queue_scan(16'h0000, 1);
    queue_scan(16'hFFFF, 1);
    queue_scan(16'h5555, 1);
    queue_scan(16'hAAAA, 1);
    queue_scan(16'h0000, 1);
    settle();

    // lowest base note and channel, velocity 1
    set_config(0, 1, 0, 1);
    queue_scan(16'hFFFF, 1);
    queue_scan(16'h0000, 1);
    settle();
    held = model_keys;

    random_config($urandom_range(1, 4));
    gesture_phase(25);
    settle();

    // packet side holds off while scans keep coming, so the input stalls
    random_config(1);
    hold_req = 400;
    repeat (25) queue_scan(16'($urandom), 1);
    settle();
    held = model_keys;

    steady_flow = 1'b1;
    random_config($urandom_range(2, 6));
    gesture_phase(25);
    settle();
    steady_flow = 1'b0;

    // longest debounce: steady keys flip on the 255th scan, the rest chatter
    random_config(255);
    steady = 16'($urandom);
    noisy = 16'($urandom) & 16'($urandom);
    for (int n = 0; n < 256; n++) queue_scan((steady & ~noisy) | (16'($urandom) & noisy), 1);
    repeat (30) queue_scan(~steady & ~noisy, 1);
    settle();
    // threshold lowered under the running counts: next disagreeing scan flips
    write_reg(REG_THRESHOLD, 32'd4);
    settings++;
    queue_scan(~steady & ~noisy, 1);
    queue_scan(16'($urandom), 1);
    settle();

    wait (scan_q.size() == 0 && note_q.size() == 0);
    repeat (40) @(negedge clk);
    $display("covered %0d scans under %0d register settings, %0d note-on and %0d note-off",
             scans_taken, settings, notes_on, notes_off);
    $display("including a long pop hold-off and a threshold change under running counts");
    if (errors == 0 && note_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("timeout with %0d scans and %0d packets still pending", scan_q.size(),
             note_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
